// File: sv/free_format_object_parser_unit_macros.svh
// Assertion macros for the free-format object parser.
// Used by the top level only; no other dependencies.
`ifndef FREE_FORMAT_OBJECT_PARSER_UNIT_MACROS_SVH
`define FREE_FORMAT_OBJECT_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FFOP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FFOP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FFOP_ASSERT(label, clk, rst_n, prop, msg)
`define FFOP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: sv/ffop_pkg.sv
// Shared types and constants of the free-format object parser.
// No dependencies.
package ffop_pkg;

  localparam int unsigned MaxDeliverBytes = 255;

  localparam logic [2:0] KindByte   = 3'd0;
  localparam logic [2:0] KindAttr   = 3'd1;
  localparam logic [2:0] KindObjEnd = 3'd2;
  localparam logic [2:0] KindCount  = 3'd3;
  localparam logic [2:0] KindOk     = 3'd4;
  localparam logic [2:0] KindError  = 3'd5;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrCount   = 2'd1;
  localparam logic [1:0] ErrObjects = 2'd2;

  localparam logic [7:0] GroupAttr = 8'd0;
  localparam logic [7:0] GroupFile = 8'd70;

  // attribute type codes as they arrive in the object
  localparam logic [7:0] AttrCodeString  = 8'd1;
  localparam logic [7:0] AttrCodeUint    = 8'd2;
  localparam logic [7:0] AttrCodeInt     = 8'd3;
  localparam logic [7:0] AttrCodeFloat   = 8'd4;
  localparam logic [7:0] AttrCodeOctets  = 8'd5;
  localparam logic [7:0] AttrCodeBits    = 8'd6;
  localparam logic [7:0] AttrCodeTime    = 8'd7;
  localparam logic [7:0] AttrCodeList    = 8'd254;
  localparam logic [7:0] AttrCodeExtList = 8'd255;

  // attribute types as reported
  localparam logic [3:0] AttrTypeString  = 4'd0;
  localparam logic [3:0] AttrTypeUint    = 4'd1;
  localparam logic [3:0] AttrTypeInt     = 4'd2;
  localparam logic [3:0] AttrTypeFloat   = 4'd3;
  localparam logic [3:0] AttrTypeOctets  = 4'd4;
  localparam logic [3:0] AttrTypeBits    = 4'd5;
  localparam logic [3:0] AttrTypeTime    = 4'd6;
  localparam logic [3:0] AttrTypeList    = 4'd7;
  localparam logic [3:0] AttrTypeExtList = 4'd8;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // one result beat
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [3:0]  attr_type;
    logic [31:0] unsigned_value;
    logic [31:0] signed_value;
    logic [47:0] time_value;
    logic [63:0] float_bits;
    logic        float_is_double;
    logic        value_valid;
    logic [7:0]  payload_length;
    logic [7:0]  object_count;
    logic [1:0]  error_code;
  } result_t;

  // front to queue: up to three results of one item
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } batch_t;

endpackage

// File: sv/ffop_front.sv
// Front part: accepts bytes, tracks header/object state, forms result batches.
// Depends on ffop_pkg.
module ffop_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 header_start_i,
  input  logic                 buffer_end_i,
  input  logic [7:0]           group_i,
  input  logic                 q_space_i,
  output logic                 b_valid_o,
  output ffop_pkg::batch_t     b_o
);

  typedef enum logic [4:0] {
    PhCount = 5'b00001,
    PhLenLo = 5'b00010,
    PhLenHi = 5'b00100,
    PhBody  = 5'b01000,
    PhDone  = 5'b10000
  } phase_e;

  phase_e      phase_q, phase_d, ph;
  logic        exp_q;
  logic [7:0]  left_q, left_d, left_c;
  logic [15:0] olen_q, olen_d, olen_c;
  logic [15:0] pos_q, pos_d, pos_c;
  logic [7:0]  code_q, code_d, code_c;
  logic [7:0]  alen_q, alen_d, alen_c;
  logic [63:0] acc_q, acc_d, acc_c;
  logic        raw_q, raw_d, raw_c;
  logic [7:0]  cnt_q, cnt_d, cnt_c;
  logic        go;

  assign in_ready_o = q_space_i;
  assign go = in_valid_i && in_ready_o;
  assign b_valid_o = go;

  // decode the finished attribute into a result
  function automatic ffop_pkg::result_t attr_res(logic raw, logic [7:0] code,
                                                 logic [7:0] len, logic [63:0] a);
    ffop_pkg::result_t r;
    r = '0;
    r.kind = ffop_pkg::KindAttr;
    r.payload_length = len;
    if (raw) begin
      r.attr_type = ffop_pkg::AttrTypeOctets;
    end else begin
      r.value_valid = 1'b1;
      case (code)
        ffop_pkg::AttrCodeString: r.attr_type = ffop_pkg::AttrTypeString;
        ffop_pkg::AttrCodeUint: begin
          r.attr_type = ffop_pkg::AttrTypeUint;
          if (len == 8'd1) r.unsigned_value = {24'd0, a[7:0]};
          else if (len == 8'd2) r.unsigned_value = {16'd0, a[15:0]};
          else if (len == 8'd4) r.unsigned_value = a[31:0];
          else r.value_valid = 1'b0;
        end
        ffop_pkg::AttrCodeInt: begin
          r.attr_type = ffop_pkg::AttrTypeInt;
          if (len == 8'd1) r.signed_value = {{24{a[7]}}, a[7:0]};
          else if (len == 8'd2) r.signed_value = {{16{a[15]}}, a[15:0]};
          else if (len == 8'd4) r.signed_value = a[31:0];
          else r.value_valid = 1'b0;
        end
        ffop_pkg::AttrCodeFloat: begin
          r.attr_type = ffop_pkg::AttrTypeFloat;
          if (len == 8'd4) r.float_bits = {32'd0, a[31:0]};
          else if (len == 8'd8) begin
            r.float_bits = a;
            r.float_is_double = 1'b1;
          end else r.value_valid = 1'b0;
        end
        ffop_pkg::AttrCodeOctets: r.attr_type = ffop_pkg::AttrTypeOctets;
        ffop_pkg::AttrCodeBits:   r.attr_type = ffop_pkg::AttrTypeBits;
        ffop_pkg::AttrCodeTime: begin
          r.attr_type = ffop_pkg::AttrTypeTime;
          if (len == 8'd6) r.time_value = a[47:0];
          else r.value_valid = 1'b0;
        end
        ffop_pkg::AttrCodeList:    r.attr_type = ffop_pkg::AttrTypeList;
        ffop_pkg::AttrCodeExtList: r.attr_type = ffop_pkg::AttrTypeExtList;
        default: r.attr_type = ffop_pkg::AttrTypeOctets;
      endcase
    end
    return r;
  endfunction

  // per-item step
  always_comb begin
    ffop_pkg::result_t rs [3];
    ffop_pkg::result_t t;
    logic [1:0]  n;
    logic        fin;
    logic [15:0] dl;
    logic [15:0] k;
    logic        acc_en;
    ph = phase_q; left_c = left_q; olen_c = olen_q; pos_c = pos_q;
    code_c = code_q; alen_c = alen_q; acc_c = acc_q; raw_c = raw_q; cnt_c = cnt_q;
    rs[0] = '0; rs[1] = '0; rs[2] = '0; n = 2'd0; fin = 1'b0; t = '0;
    k = pos_q - 16'd2;
    dl = '0;
    acc_en = (code_q == ffop_pkg::AttrCodeUint) || (code_q == ffop_pkg::AttrCodeInt) ||
             (code_q == ffop_pkg::AttrCodeFloat) || (code_q == ffop_pkg::AttrCodeTime);
    if (header_start_i) begin
      ph = PhCount; left_c = '0; olen_c = '0; pos_c = '0; code_c = '0;
      alen_c = '0; acc_c = '0; raw_c = 1'b0; cnt_c = '0;
      k = 16'hFFFE;
      acc_en = 1'b0;
    end
    if (buffer_end_i) begin
      if (ph == PhCount) begin
        t = '0; t.kind = ffop_pkg::KindError; t.error_code = ffop_pkg::ErrCount;
        rs[0] = t; n = 2'd1;
      end else if (ph != PhDone) begin
        t = '0; t.kind = ffop_pkg::KindError; t.error_code = ffop_pkg::ErrObjects;
        t.object_count = cnt_c; rs[0] = t; n = 2'd1;
      end
      ph = PhDone;
    end else begin
      case (ph)
        PhCount: begin
          cnt_c = data_byte_i;
          if (!exp_q) begin
            t = '0; t.kind = ffop_pkg::KindCount; t.object_count = data_byte_i;
            rs[0] = t; n = 2'd1; ph = PhDone;
          end else if (data_byte_i == 8'd0) begin
            t = '0; t.kind = ffop_pkg::KindOk; rs[0] = t; n = 2'd1; ph = PhDone;
          end else begin
            left_c = data_byte_i; ph = PhLenLo;
          end
        end
        PhLenLo: begin
          olen_c = {8'd0, data_byte_i}; ph = PhLenHi;
        end
        PhLenHi: begin
          olen_c = {data_byte_i, olen_q[7:0]};
          pos_c = '0; code_c = '0; alen_c = '0; acc_c = '0;
          raw_c = (group_i == ffop_pkg::GroupAttr) && (olen_c < 16'd2);
          if (olen_c == 16'd0) fin = 1'b1;
          else ph = PhBody;
        end
        PhBody: begin
          t = '0; t.kind = ffop_pkg::KindByte; t.byte_value = data_byte_i;
          if (group_i == ffop_pkg::GroupFile) begin
            if (pos_q < 16'(ffop_pkg::MaxDeliverBytes)) begin
              rs[0] = t; n = 2'd1;
            end
          end else if (group_i == ffop_pkg::GroupAttr) begin
            if (raw_q) begin
              if (pos_q >= 16'd2 || olen_q < 16'd2) begin
                rs[0] = t; n = 2'd1;
              end
            end else if (pos_q == 16'd0) begin
              code_c = data_byte_i;
            end else if (pos_q == 16'd1) begin
              alen_c = data_byte_i;
              if ((olen_q - 16'd2) < {8'd0, data_byte_i}) raw_c = 1'b1;
            end else if (k < {8'd0, alen_q}) begin
              if (!acc_en) begin
                rs[0] = t; n = 2'd1;
              end else if (k < 16'd8) begin
                acc_c = acc_q | ({56'd0, data_byte_i} << {k[2:0], 3'b000});
              end
            end
          end
          pos_c = pos_q + 16'd1;
          if (pos_c >= olen_q) fin = 1'b1;
        end
        default: ;
      endcase
      if (fin) begin
        if (group_i == ffop_pkg::GroupAttr) begin
          rs[n] = attr_res(raw_c, code_c, alen_c, acc_c); n = n + 2'd1;
        end else if (group_i == ffop_pkg::GroupFile) begin
          dl = (olen_c > 16'(ffop_pkg::MaxDeliverBytes)) ?
               16'(ffop_pkg::MaxDeliverBytes) : olen_c;
          if (dl > 16'd255) dl = 16'd255;
          t = '0; t.kind = ffop_pkg::KindObjEnd; t.payload_length = dl[7:0];
          rs[n] = t; n = n + 2'd1;
        end
        left_c = left_c - 8'd1;
        if (left_c == 8'd0) begin
          t = '0; t.kind = ffop_pkg::KindOk; t.object_count = cnt_c;
          rs[n] = t; n = n + 2'd1; ph = PhDone;
        end else ph = PhLenLo;
      end
    end
    b_o.n = n; b_o.r0 = rs[0]; b_o.r1 = rs[1]; b_o.r2 = rs[2];
    phase_d = go ? ph : phase_q;
    left_d = go ? left_c : left_q;   olen_d = go ? olen_c : olen_q;
    pos_d = go ? pos_c : pos_q;      code_d = go ? code_c : code_q;
    alen_d = go ? alen_c : alen_q;   acc_d = go ? acc_c : acc_q;
    raw_d = go ? raw_c : raw_q;      cnt_d = go ? cnt_c : cnt_q;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCount; exp_q <= 1'b1; left_q <= '0; olen_q <= '0; pos_q <= '0;
      code_q <= '0; alen_q <= '0; acc_q <= '0; raw_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (cfg_we_i) exp_q <= cfg_wdata_i;
      phase_q <= phase_d; left_q <= left_d; olen_q <= olen_d; pos_q <= pos_d;
      code_q <= code_d; alen_q <= alen_d; acc_q <= acc_d; raw_q <= raw_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/ffop_back.sv
// Back part: batch queue and serialiser of result beats onto the output.
// Depends on ffop_pkg.
module ffop_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               b_valid_i,
  input  ffop_pkg::batch_t   b_i,
  output logic               q_space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ffop_pkg::result_t  res_o,
  output logic [ffop_pkg::QPtrW:0] fill_o
);

  ffop_pkg::batch_t q_q [ffop_pkg::QDepth];
  logic [ffop_pkg::QPtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [ffop_pkg::QPtrW:0]   cnt_q, cnt_d;
  logic [1:0]                 sub_q, sub_d;
  logic                       push, pop, head_v;
  ffop_pkg::batch_t           head;

  // empty batches are dropped at the door
  assign push = b_valid_i && (b_i.n != 2'd0);
  assign q_space_o = cnt_q < (ffop_pkg::QPtrW+1)'(ffop_pkg::QDepth);
  assign head = q_q[rp_q];
  assign head_v = cnt_q != '0;
  assign out_valid_o = head_v;
  assign fill_o = cnt_q;
  assign pop = head_v && out_ready_i && (sub_q == head.n - 2'd1);

  always_comb begin
    case (sub_q)
      2'd0: res_o = head.r0;
      2'd1: res_o = head.r1;
      default: res_o = head.r2;
    endcase
    wp_d = push ? wp_q + 1'b1 : wp_q;
    rp_d = pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (ffop_pkg::QPtrW+1)'(push) - (ffop_pkg::QPtrW+1)'(pop);
    sub_d = sub_q;
    if (head_v && out_ready_i) sub_d = pop ? 2'd0 : sub_q + 2'd1;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; sub_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d; sub_q <= sub_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= b_i;
  end

endmodule

// File: sv/free_format_object_parser_unit.sv
// Top level of the free-format object parser: front, batch queue, serialiser.
// Depends on ffop_pkg, ffop_front, ffop_back and the macros header.
//
//  channel  | handshake                | beat
//  ---------+--------------------------+-------------------------------------
//  config   | cfg_we_i                 | cfg_wdata_i (expects_contents)
//  input    | in_valid_i / in_ready_o  | data_byte_i .. variation_i
//  output   | out_valid_o / out_ready_i| result_kind_o .. error_code_o
//
// One input beat a cycle; its 0 to 3 results leave one a cycle when ready.
// A four-entry batch queue separates the sides; input stalls only when full.
// Reset is asynchronous, active low; no clearing pass is needed.
`include "free_format_object_parser_unit_macros.svh"
module free_format_object_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        header_start_i,
  input  logic        buffer_end_i,
  input  logic [7:0]  group_i,
  input  logic [7:0]  variation_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  byte_value_o,
  output logic [3:0]  attr_type_o,
  output logic [31:0] unsigned_value_o,
  output logic signed [31:0] signed_value_o,
  output logic [47:0] time_value_o,
  output logic [63:0] float_bits_o,
  output logic        float_is_double_o,
  output logic        value_valid_o,
  output logic [7:0]  payload_length_o,
  output logic [7:0]  object_count_o,
  output logic [1:0]  error_code_o
);

  logic              q_space, b_valid, var_unused;
  ffop_pkg::batch_t  batch;
  ffop_pkg::result_t res;
  logic [ffop_pkg::QPtrW:0] fill;

  // variation carries no meaning for the results
  assign var_unused = ^variation_i;

  ffop_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .data_byte_i, .header_start_i, .buffer_end_i, .group_i,
    .q_space_i(q_space), .b_valid_o(b_valid), .b_o(batch)
  );

  ffop_back u_back (
    .clk_i, .rst_ni, .b_valid_i(b_valid), .b_i(batch), .q_space_o(q_space),
    .out_valid_o, .out_ready_i, .res_o(res), .fill_o(fill)
  );

  assign result_kind_o     = res.kind;
  assign byte_value_o      = res.byte_value;
  assign attr_type_o       = res.attr_type;
  assign unsigned_value_o  = res.unsigned_value;
  assign signed_value_o    = res.signed_value;
  assign time_value_o      = res.time_value;
  assign float_bits_o      = res.float_bits;
  assign float_is_double_o = res.float_is_double & ~(var_unused & 1'b0);
  assign value_valid_o     = res.value_valid;
  assign payload_length_o  = res.payload_length;
  assign object_count_o    = res.object_count;
  assign error_code_o      = res.error_code;

  // checks
  `FFOP_ASSERT(a_fill_max, clk_i, rst_ni, fill <= (ffop_pkg::QPtrW+1)'(ffop_pkg::QDepth), "queue overfilled")
  `FFOP_ASSERT(a_ready_full, clk_i, rst_ni, in_ready_o == (fill != (ffop_pkg::QPtrW+1)'(ffop_pkg::QDepth)), "ready disagrees with fill")
  `FFOP_ASSERT(a_valid_fill, clk_i, rst_ni, out_valid_o == (fill != '0), "valid disagrees with fill")
  `FFOP_ASSERT_NEXT(a_kind_range, clk_i, rst_ni, out_valid_o, result_kind_o <= ffop_pkg::KindError || !out_valid_o, "bad result kind")

endmodule

// File: tb/sv/ffop_result_checker.sv
// Result checker for the free-format object parser: watches both channels,
// predicts each beat's results and compares them. Depends on ffop_pkg.
module ffop_result_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        data_byte_i,
  input  logic              header_start_i,
  input  logic              buffer_end_i,
  input  logic [7:0]        group_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  ffop_pkg::result_t result_i,
  output int                error_count_o,
  output int                pending_o
);

  typedef enum logic [4:0] {
    PhCount = 5'b00001,
    PhLenLo = 5'b00010,
    PhLenHi = 5'b00100,
    PhBody  = 5'b01000,
    PhDone  = 5'b10000
  } phase_e;

  // predictor state
  logic        contents_on;
  phase_e      phase;
  logic [7:0]  objs_left;
  logic [15:0] obj_len;
  logic [15:0] pos;
  logic [7:0]  attr_code;
  logic [7:0]  attr_len;
  logic [63:0] acc;
  logic        raw;
  logic [7:0]  count_latch;

  ffop_pkg::result_t expected_results[$];
  int                errors;

  assign error_count_o = errors;
  assign pending_o     = expected_results.size();

  function automatic ffop_pkg::result_t blank(logic [2:0] kind);
    ffop_pkg::result_t r;
    r = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic ffop_pkg::result_t attr_result();
    ffop_pkg::result_t r;
    r = blank(ffop_pkg::KindAttr);
    r.payload_length = attr_len;
    if (raw) begin
      r.attr_type = ffop_pkg::AttrTypeOctets;
      return r;
    end
    r.value_valid = 1'b1;
    case (attr_code)
      ffop_pkg::AttrCodeString: r.attr_type = ffop_pkg::AttrTypeString;
      ffop_pkg::AttrCodeUint: begin
        r.attr_type = ffop_pkg::AttrTypeUint;
        if (attr_len == 1) r.unsigned_value = {24'd0, acc[7:0]};
        else if (attr_len == 2) r.unsigned_value = {16'd0, acc[15:0]};
        else if (attr_len == 4) r.unsigned_value = acc[31:0];
        else r.value_valid = 1'b0;
      end
      ffop_pkg::AttrCodeInt: begin
        r.attr_type = ffop_pkg::AttrTypeInt;
        if (attr_len == 1) r.signed_value = {{24{acc[7]}}, acc[7:0]};
        else if (attr_len == 2) r.signed_value = {{16{acc[15]}}, acc[15:0]};
        else if (attr_len == 4) r.signed_value = acc[31:0];
        else r.value_valid = 1'b0;
      end
      ffop_pkg::AttrCodeFloat: begin
        r.attr_type = ffop_pkg::AttrTypeFloat;
        if (attr_len == 4) r.float_bits = {32'd0, acc[31:0]};
        else if (attr_len == 8) begin
          r.float_bits = acc;
          r.float_is_double = 1'b1;
        end else r.value_valid = 1'b0;
      end
      ffop_pkg::AttrCodeOctets: r.attr_type = ffop_pkg::AttrTypeOctets;
      ffop_pkg::AttrCodeBits:   r.attr_type = ffop_pkg::AttrTypeBits;
      ffop_pkg::AttrCodeTime: begin
        r.attr_type = ffop_pkg::AttrTypeTime;
        if (attr_len == 6) r.time_value = acc[47:0];
        else r.value_valid = 1'b0;
      end
      ffop_pkg::AttrCodeList:    r.attr_type = ffop_pkg::AttrTypeList;
      ffop_pkg::AttrCodeExtList: r.attr_type = ffop_pkg::AttrTypeExtList;
      default:                   r.attr_type = ffop_pkg::AttrTypeOctets;
    endcase
    return r;
  endfunction

  function automatic void close_object(logic [7:0] grp);
    ffop_pkg::result_t r;
    if (grp == ffop_pkg::GroupAttr) expected_results.push_back(attr_result());
    else if (grp == ffop_pkg::GroupFile) begin
      r = blank(ffop_pkg::KindObjEnd);
      r.payload_length = (obj_len > ffop_pkg::MaxDeliverBytes) ?
                         8'(ffop_pkg::MaxDeliverBytes) : obj_len[7:0];
      expected_results.push_back(r);
    end
    objs_left = objs_left - 8'd1;
    if (objs_left == 0) begin
      r = blank(ffop_pkg::KindOk);
      r.object_count = count_latch;
      expected_results.push_back(r);
      phase = PhDone;
    end else phase = PhLenLo;
  endfunction

  function automatic void body_byte(logic [7:0] grp, logic [7:0] b);
    ffop_pkg::result_t r;
    logic [15:0] k;
    r = blank(ffop_pkg::KindByte);
    r.byte_value = b;
    if (grp == ffop_pkg::GroupFile) begin
      if (pos < ffop_pkg::MaxDeliverBytes) expected_results.push_back(r);
    end else if (grp == ffop_pkg::GroupAttr) begin
      if (raw) begin
        if (pos >= 2 || obj_len < 2) expected_results.push_back(r);
      end else if (pos == 0) attr_code = b;
      else if (pos == 1) begin
        attr_len = b;
        if (obj_len - 16'd2 < {8'd0, b}) raw = 1'b1;
      end else begin
        k = pos - 16'd2;
        if (k < attr_len) begin
          if (!(attr_code inside {ffop_pkg::AttrCodeUint, ffop_pkg::AttrCodeInt,
                                  ffop_pkg::AttrCodeFloat, ffop_pkg::AttrCodeTime}))
            expected_results.push_back(r);
          else if (k < 8) acc = acc | (64'(b) << (8 * k));
        end
      end
    end
  endfunction

  function automatic void clear_parser();
    phase = PhCount; objs_left = '0; obj_len = '0; pos = '0;
    attr_code = '0; attr_len = '0; acc = '0; raw = 1'b0; count_latch = '0;
  endfunction

  // predict the results of one accepted beat
  function automatic void predict_beat(logic [7:0] b, logic hs, logic be, logic [7:0] grp);
    ffop_pkg::result_t r;
    if (hs) clear_parser();
    if (be) begin
      if (phase == PhCount) begin
        r = blank(ffop_pkg::KindError);
        r.error_code = ffop_pkg::ErrCount;
        expected_results.push_back(r);
      end else if (phase != PhDone) begin
        r = blank(ffop_pkg::KindError);
        r.error_code = ffop_pkg::ErrObjects;
        r.object_count = count_latch;
        expected_results.push_back(r);
      end
      phase = PhDone;
      return;
    end
    case (phase)
      PhCount: begin
        count_latch = b;
        if (!contents_on) begin
          r = blank(ffop_pkg::KindCount);
          r.object_count = b;
          expected_results.push_back(r);
          phase = PhDone;
        end else if (b == 0) begin
          expected_results.push_back(blank(ffop_pkg::KindOk));
          phase = PhDone;
        end else begin
          objs_left = b;
          phase = PhLenLo;
        end
      end
      PhLenLo: begin
        obj_len = {8'd0, b};
        phase = PhLenHi;
      end
      PhLenHi: begin
        obj_len = {b, obj_len[7:0]};
        pos = '0; attr_code = '0; attr_len = '0; acc = '0;
        raw = (grp == ffop_pkg::GroupAttr) && (obj_len < 2);
        if (obj_len == 0) close_object(grp);
        else phase = PhBody;
      end
      PhBody: begin
        body_byte(grp, b);
        pos = pos + 16'd1;
        if (pos >= obj_len) close_object(grp);
      end
      default: ;
    endcase
  endfunction

  // compare one delivered result beat with the oldest expectation
  task automatic check_result(ffop_pkg::result_t got);
    ffop_pkg::result_t exp_r;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result beat %p", $time, got);
      errors++;
      return;
    end
    exp_r = expected_results.pop_front();
    if (got !== exp_r) begin
      $display("%0t: result mismatch: expected %p, actual %p", $time, exp_r, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contents_on = 1'b1;
      clear_parser();
      expected_results.delete();
      errors = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(result_i);
      if (cfg_we_i) contents_on = cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        predict_beat(data_byte_i, header_start_i, buffer_end_i, group_i);
    end
  end

endmodule

// File: tb/sv/free_format_object_parser_unit_tb.sv
// Testbench top for the free-format object parser: clock, reset, stimulus
// and verdict. Depends on ffop_pkg, ffop_result_checker and the block.
module free_format_object_parser_unit_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0, cfg_wdata = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [7:0] data_byte = '0, group = '0, variation = '0;
  logic header_start = 1'b0, buffer_end = 1'b0;
  logic out_valid, out_ready = 1'b0;
  wire ffop_pkg::result_t res;
  int error_count, pending;
  int sent;
  bit quiet_tail = 1'b0;
  bit long_hold = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  free_format_object_parser_unit u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .data_byte_i(data_byte), .header_start_i(header_start),
    .buffer_end_i(buffer_end), .group_i(group), .variation_i(variation),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_kind_o(res.kind), .byte_value_o(res.byte_value),
    .attr_type_o(res.attr_type), .unsigned_value_o(res.unsigned_value),
    .signed_value_o(res.signed_value), .time_value_o(res.time_value),
    .float_bits_o(res.float_bits), .float_is_double_o(res.float_is_double),
    .value_valid_o(res.value_valid), .payload_length_o(res.payload_length),
    .object_count_o(res.object_count), .error_code_o(res.error_code)
  );

  ffop_result_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .data_byte_i(data_byte), .header_start_i(header_start),
    .buffer_end_i(buffer_end), .group_i(group),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .result_i(res),
    .error_count_o(error_count), .pending_o(pending)
  );

  // one input beat; valid stays up between beats unless a random gap comes
  task automatic send_beat(logic [7:0] b, logic hs, logic be, logic [7:0] grp);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    data_byte <= b; header_start <= hs; buffer_end <= be;
    group <= grp; variation <= 8'($urandom);
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  // a header: count byte, then objects built by the caller's choice
  task automatic send_header(logic [7:0] grp, int n_obj, int max_len, bit cut);
    int len, alen, code;
    alen = 0;
    send_beat(8'(n_obj), 1'b1, 1'b0, grp);
    for (int i = 0; i < n_obj; i++) begin
      len = $urandom_range(0, max_len);
      if (grp == ffop_pkg::GroupAttr && len >= 2 && $urandom_range(0, 3) != 0) begin
        // well-formed attribute, length matching the payload mostly
        alen = (len - 2 < 9) ? $urandom_range(0, len - 2) : $urandom_range(0, 8);
        len = alen + 2 + $urandom_range(0, 1);
      end
      send_beat(8'(len), 1'b0, 1'b0, grp);
      send_beat(8'(len >> 8), 1'b0, 1'b0, grp);
      for (int k = 0; k < len; k++) begin
        if (cut && $urandom_range(0, 30) == 0) begin
          send_beat(8'($urandom), 1'b0, 1'b1, grp);
          return;
        end
        if (grp == ffop_pkg::GroupAttr && k == 0) begin
          code = $urandom_range(0, 9);
          send_beat(code == 8 ? ffop_pkg::AttrCodeList :
                    code == 9 ? ffop_pkg::AttrCodeExtList : 8'(code),
                    1'b0, 1'b0, grp);
        end else if (grp == ffop_pkg::GroupAttr && k == 1)
          send_beat($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'(alen),
                    1'b0, 1'b0, grp);
        else send_beat(8'($urandom), 1'b0, 1'b0, grp);
      end
    end
    if (cut) send_beat(8'($urandom), 1'b0, 1'b1, grp);
  endtask

  task automatic attr(logic [7:0] code, int plen, logic [63:0] v);
    send_beat(8'(plen + 2), 1'b0, 1'b0, ffop_pkg::GroupAttr);
    send_beat(8'd0, 1'b0, 1'b0, ffop_pkg::GroupAttr);
    send_beat(code, 1'b0, 1'b0, ffop_pkg::GroupAttr);
    send_beat(8'(plen), 1'b0, 1'b0, ffop_pkg::GroupAttr);
    for (int k = 0; k < plen; k++) send_beat(v[8*k +: 8], 1'b0, 1'b0, ffop_pkg::GroupAttr);
  endtask

  // stop offering and wait for every expected result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic v);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (60) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: integer, signed, float, time, string, raw and error cases
    send_beat(8'd9, 1'b1, 1'b0, ffop_pkg::GroupAttr);
    attr(ffop_pkg::AttrCodeUint, 4, 64'hFFFF_FFFF);
    attr(ffop_pkg::AttrCodeInt, 1, 64'h80);
    attr(ffop_pkg::AttrCodeInt, 2, 64'h7FFF);
    attr(ffop_pkg::AttrCodeFloat, 8, 64'hFFFF_FFFF_FFFF_FFFF);
    attr(ffop_pkg::AttrCodeTime, 6, 64'h0000_FFFF_FFFF_FFFF);
    attr(ffop_pkg::AttrCodeUint, 3, 64'h123456);
    attr(ffop_pkg::AttrCodeString, 2, 64'h4241);
    // truncated attribute
    send_beat(8'd3, 1'b0, 1'b0, ffop_pkg::GroupAttr);
    send_beat(8'd0, 1'b0, 1'b0, ffop_pkg::GroupAttr);
    send_beat(ffop_pkg::AttrCodeOctets, 1'b0, 1'b0, ffop_pkg::GroupAttr);
    send_beat(8'd200, 1'b0, 1'b0, ffop_pkg::GroupAttr);
    send_beat(8'hAA, 1'b0, 1'b0, ffop_pkg::GroupAttr);
    // short attribute
    send_beat(8'd1, 1'b0, 1'b0, ffop_pkg::GroupAttr);
    send_beat(8'd0, 1'b0, 1'b0, ffop_pkg::GroupAttr);
    send_beat(8'h55, 1'b0, 1'b0, ffop_pkg::GroupAttr);
    send_beat(8'd0, 1'b0, 1'b1, ffop_pkg::GroupAttr);
    send_beat(8'd0, 1'b1, 1'b1, ffop_pkg::GroupAttr);
    send_beat(8'd0, 1'b1, 1'b0, ffop_pkg::GroupFile);
    wait_drained();

    write_cfg(1'b0);
    send_beat(8'd255, 1'b1, 1'b0, 8'd12);
    send_beat(8'd1, 1'b0, 1'b0, 8'd12);
    wait_drained();
    write_cfg(1'b1);

    // group 70 object past the delivery limit, 257 bytes
    send_beat(8'd1, 1'b1, 1'b0, ffop_pkg::GroupFile);
    send_beat(8'd1, 1'b0, 1'b0, ffop_pkg::GroupFile);
    send_beat(8'd1, 1'b0, 1'b0, ffop_pkg::GroupFile);
    long_hold = 1'b1;
    for (int k = 0; k < 257; k++) send_beat(8'($urandom), 1'b0, 1'b0, ffop_pkg::GroupFile);
    wait_drained();

    // random headers, mostly well-formed
    while (sent < 420) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_header(ffop_pkg::GroupAttr, $urandom_range(1, 4), 12, 1'b0);
        4, 5:       send_header(ffop_pkg::GroupFile, $urandom_range(1, 3), 8, 1'b0);
        6:          send_header(8'($urandom), $urandom_range(0, 3), 6, 1'b0);
        7:          send_header(ffop_pkg::GroupAttr, $urandom_range(1, 3), 10, 1'b1);
        8:          send_beat(8'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 8'($urandom));
        default: begin
          wait_drained();
          write_cfg(1'($urandom_range(0, 1)));
        end
      endcase
      if (sent > 370) quiet_tail = 1'b1;
    end
    wait_drained();

    if (error_count == 0) $display("free_format_object_parser_unit_tb: clean");
    else $display("free_format_object_parser_unit_tb: errors");
    $finish;
  end

  initial begin
    #1000000;
    $display("free_format_object_parser_unit_tb: errors");
    $finish;
  end

endmodule
